### sv/sjq_pkg.sv
// sjq_pkg: shared types, constants and state encoding for the job queue.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sjq_pkg;
    localparam int TABLE_SLOTS_DEF = 1024;
    localparam int MAX_JOBS_DEF    = 256;
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_EMPTY  = 2'd0,
        ST_WAIT   = 2'd1,
        ST_ACTIVE = 2'd2,
        ST_DONE   = 2'd3
    } slot_st_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] job_id;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] active_job;
        logic [8:0]         waiting_count;
        logic               overflow;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_APPLY,
        S_POP_CHK,
        S_POP_RD,
        S_POP_HASH,
        S_EMIT
    } eng_state_t;
endpackage
`default_nettype wire

### sv/sjq_cmd_fifo.sv
// sjq_cmd_fifo: two-entry queue between the front (input port) and the engine.
// Depends on sjq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sjq_cmd_fifo
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sjq_pkg::in_item_t din,
    output logic                   full,
    input  wire logic              pop,
    output sjq_pkg::in_item_t      dout,
    output logic                   empty
);
    sjq_pkg::in_item_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop && !empty)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
        end
    end
endmodule
`default_nettype wire

### sv/sjq_engine.sv
// sjq_engine: back end; hash table probe, job FIFO and server state sequencer.
// Depends on sjq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sjq_engine
#(
    parameter int TABLE_SLOTS = sjq_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_JOBS    = sjq_pkg::MAX_JOBS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire sjq_pkg::in_item_t cmd,
    output logic                   cmd_take,
    output logic                   res_valid,
    output sjq_pkg::out_item_t     res,
    input  wire logic              res_ready
);
    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int FW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int PW = FW + 1;
    localparam logic [SW:0] SLOTS_N = (SW + 1)'(TABLE_SLOTS);
    localparam logic [PW:0] JOBS_N  = (PW + 1)'(MAX_JOBS);

    // Table: key and status memories, one port each.
    logic [31:0]         key_mem [TABLE_SLOTS];
    sjq_pkg::slot_st_t   st_mem  [TABLE_SLOTS];
    logic [31:0]         fifo_mem [MAX_JOBS];

    sjq_pkg::eng_state_t state_reg, state_next;
    logic [SW:0]   clr_reg;
    logic [1:0]    op_reg;
    logic [31:0]   key_reg;      // id being probed
    logic [SW-1:0] idx_reg;
    logic [SW:0]   nprobe_reg;
    logic [31:0]   rd_key_reg;
    sjq_pkg::slot_st_t rd_st_reg;
    logic          pop_mode_reg; // probe belongs to the idle pop
    logic [31:0]   cur_reg;
    logic [8:0]    wait_reg;
    logic [PW-1:0] head_reg, tail_reg;
    logic          ovf_reg;
    logic [31:0]   fifo_rd_reg;
    logic          res_valid_reg;
    sjq_pkg::out_item_t res_reg;

    logic [PW-1:0] fill;
    logic [PW-1:0] span_m1;
    logic          found, empty_slot, probe_end;
    logic [SW-1:0] idx_inc;
    logic [31:0]   hash_prod;
    logic          emit_fire;

    assign span_m1   = PW'(2 * MAX_JOBS - 1);
    assign fill      = (tail_reg >= head_reg) ? (tail_reg - head_reg)
                                              : PW'(tail_reg + PW'(2 * MAX_JOBS) - head_reg);
    assign found      = (rd_key_reg == key_reg) && (rd_key_reg != 32'd0);
    assign empty_slot = (rd_key_reg == 32'd0);
    assign probe_end  = found || empty_slot || (nprobe_reg == SLOTS_N);
    assign idx_inc    = (idx_reg == SW'(TABLE_SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign hash_prod  = key_reg * sjq_pkg::HASH_MULT;
    // result register frees the engine; it only waits here if the last result is unpopped
    assign emit_fire  = (state_reg == sjq_pkg::S_EMIT) && (!res_valid_reg || res_ready);
    assign cmd_take   = (state_reg == sjq_pkg::S_IDLE) && cmd_valid;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p, input logic [PW-1:0] m);
        ptr_inc = (p == m) ? '0 : p + 1'b1;
    endfunction

    // queue position (modulo twice the depth) to storage index
    function automatic logic [FW-1:0] fifo_idx(input logic [PW-1:0] p);
        fifo_idx = (p >= PW'(MAX_JOBS)) ? FW'(p - PW'(MAX_JOBS)) : FW'(p);
    endfunction

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sjq_pkg::S_CLEAR:     if (clr_reg == SLOTS_N - 1'b1) state_next = sjq_pkg::S_IDLE;
            sjq_pkg::S_IDLE:
            begin
                if (cmd_take)
                begin
                    priority if (cmd.opcode == sjq_pkg::OP_ADD || cmd.opcode == sjq_pkg::OP_CANCEL)
                        state_next = (cmd.job_id != 0) ? sjq_pkg::S_HASH : sjq_pkg::S_POP_CHK;
                    else if (cmd.opcode == sjq_pkg::OP_FINISH && cur_reg != 32'd0)
                        state_next = sjq_pkg::S_HASH;
                    else
                        state_next = sjq_pkg::S_POP_CHK;
                end
            end
            sjq_pkg::S_HASH:      state_next = sjq_pkg::S_PROBE_RD;
            sjq_pkg::S_PROBE_RD:  state_next = sjq_pkg::S_PROBE_CHK;
            sjq_pkg::S_PROBE_CHK: state_next = probe_end ? sjq_pkg::S_APPLY : sjq_pkg::S_PROBE_RD;
            sjq_pkg::S_APPLY:     state_next = sjq_pkg::S_POP_CHK;
            sjq_pkg::S_POP_CHK:
                state_next = (cur_reg == 32'd0 && fill != '0) ? sjq_pkg::S_POP_RD
                                                              : sjq_pkg::S_EMIT;
            sjq_pkg::S_POP_RD:    state_next = sjq_pkg::S_POP_HASH;
            sjq_pkg::S_POP_HASH:  state_next = sjq_pkg::S_HASH;
            sjq_pkg::S_EMIT:      state_next = emit_fire ? sjq_pkg::S_IDLE : sjq_pkg::S_EMIT;
            default:              state_next = sjq_pkg::S_IDLE;
        endcase
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (state_reg == sjq_pkg::S_CLEAR)
        begin
            key_mem[clr_reg[SW-1:0]] <= 32'd0;
            st_mem[clr_reg[SW-1:0]]  <= sjq_pkg::ST_EMPTY;
        end
        else if (state_reg == sjq_pkg::S_APPLY && !pop_mode_reg)
        begin
            if (op_reg == sjq_pkg::OP_ADD && (nprobe_reg != SLOTS_N || found || empty_slot)
                && !(found && (rd_st_reg == sjq_pkg::ST_WAIT || rd_st_reg == sjq_pkg::ST_ACTIVE))
                && !(cur_reg != 32'd0 && fill >= JOBS_N[PW-1:0] && MAX_JOBS < 2 * MAX_JOBS
                     && {1'b0, fill} >= JOBS_N))
            begin
                if (found || empty_slot)
                begin
                    key_mem[idx_reg] <= key_reg;
                    st_mem[idx_reg]  <= (cur_reg == 32'd0) ? sjq_pkg::ST_ACTIVE
                                                           : sjq_pkg::ST_WAIT;
                end
            end
            else if (op_reg == sjq_pkg::OP_CANCEL && found
                     && (rd_st_reg == sjq_pkg::ST_WAIT || rd_st_reg == sjq_pkg::ST_ACTIVE))
            begin
                st_mem[idx_reg] <= sjq_pkg::ST_DONE;
            end
            else if (op_reg == sjq_pkg::OP_FINISH && found)
            begin
                st_mem[idx_reg] <= sjq_pkg::ST_DONE;
            end
        end
        else if (state_reg == sjq_pkg::S_APPLY && pop_mode_reg && found
                 && rd_st_reg == sjq_pkg::ST_WAIT)
        begin
            st_mem[idx_reg] <= sjq_pkg::ST_ACTIVE;
        end
        if (state_reg == sjq_pkg::S_PROBE_RD)
        begin
            rd_key_reg <= key_mem[idx_reg];
            rd_st_reg  <= st_mem[idx_reg];
        end
        if (state_reg == sjq_pkg::S_APPLY && !pop_mode_reg && op_reg == sjq_pkg::OP_ADD
            && (found || empty_slot) && cur_reg != 32'd0
            && !(found && (rd_st_reg == sjq_pkg::ST_WAIT || rd_st_reg == sjq_pkg::ST_ACTIVE))
            && {1'b0, fill} < JOBS_N)
        begin
            fifo_mem[fifo_idx(tail_reg)] <= key_reg;
        end
        if (state_reg == sjq_pkg::S_POP_CHK)
        begin
            fifo_rd_reg <= fifo_mem[fifo_idx(head_reg)];
        end
    end

    // Control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sjq_pkg::S_CLEAR;
            clr_reg       <= '0;
            op_reg        <= '0;
            key_reg       <= '0;
            idx_reg       <= '0;
            nprobe_reg    <= '0;
            pop_mode_reg  <= 1'b0;
            cur_reg       <= '0;
            wait_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                sjq_pkg::S_CLEAR: clr_reg <= clr_reg + 1'b1;
                sjq_pkg::S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        op_reg       <= cmd.opcode;
                        key_reg      <= (cmd.opcode == sjq_pkg::OP_FINISH) ? cur_reg
                                                                           : cmd.job_id;
                        pop_mode_reg <= 1'b0;
                        ovf_reg      <= 1'b0;
                    end
                end
                sjq_pkg::S_HASH:
                begin
                    idx_reg    <= SW'(hash_prod % TABLE_SLOTS);
                    nprobe_reg <= '0;
                end
                sjq_pkg::S_PROBE_RD: ;
                sjq_pkg::S_PROBE_CHK:
                begin
                    if (!probe_end)
                    begin
                        idx_reg    <= idx_inc;
                        nprobe_reg <= nprobe_reg + 1'b1;
                    end
                end
                sjq_pkg::S_APPLY:
                begin
                    if (pop_mode_reg)
                    begin
                        if (found && rd_st_reg == sjq_pkg::ST_WAIT)
                        begin
                            cur_reg <= key_reg;
                            if (wait_reg != '0) wait_reg <= wait_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        unique case (op_reg)
                            sjq_pkg::OP_ADD:
                            begin
                                if (!(found && (rd_st_reg == sjq_pkg::ST_WAIT
                                                || rd_st_reg == sjq_pkg::ST_ACTIVE)))
                                begin
                                    if (!found && !empty_slot)
                                        ovf_reg <= 1'b1;
                                    else if (cur_reg != 32'd0 && {1'b0, fill} >= JOBS_N)
                                        ovf_reg <= 1'b1;
                                    else
                                    begin
                                        if (cur_reg == 32'd0)
                                            cur_reg <= key_reg;
                                        else
                                        begin
                                            tail_reg <= ptr_inc(tail_reg, span_m1);
                                            wait_reg <= wait_reg + 1'b1;
                                        end
                                    end
                                end
                            end
                            sjq_pkg::OP_CANCEL:
                            begin
                                if (found && rd_st_reg == sjq_pkg::ST_WAIT)
                                begin
                                    if (wait_reg != '0) wait_reg <= wait_reg - 1'b1;
                                end
                                else if (found && rd_st_reg == sjq_pkg::ST_ACTIVE)
                                    cur_reg <= '0;
                            end
                            sjq_pkg::OP_FINISH: cur_reg <= '0;
                            default: ;
                        endcase
                    end
                end
                sjq_pkg::S_POP_CHK:
                begin
                    if (cur_reg == 32'd0 && fill != '0)
                        head_reg <= ptr_inc(head_reg, span_m1);
                end
                sjq_pkg::S_POP_RD:
                begin
                    key_reg      <= fifo_rd_reg;
                    pop_mode_reg <= 1'b1;
                end
                sjq_pkg::S_POP_HASH: ;
                sjq_pkg::S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        res_reg.active_job    <= cur_reg;
                        res_reg.waiting_count <= wait_reg;
                        res_reg.overflow      <= ovf_reg;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/single_server_job_queue_with_cancel.sv
// Top level: single-server job queue with lazy cancellation.
// An accepted input passes the command queue; the engine then goes from idle
// through hash, probe read and probe check (again per extra probe) to apply, and
// through pop check, pop read and pop hash back to hash per queue entry examined
// by the idle pop, then to emit; an event that needs no probe goes from idle
// through pop check to emit. One transaction is in the engine at a time; the
// result register lets the engine go on while a result waits to be popped.
// Reset: asynchronous, active low; no transaction is taken while every table slot is cleared.
`timescale 1ns / 1ps
`default_nettype none
module single_server_job_queue_with_cancel
#(
    parameter int TABLE_SLOTS = sjq_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_JOBS    = sjq_pkg::MAX_JOBS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire sjq_pkg::in_item_t  in_item,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output sjq_pkg::out_item_t      out_item
);
    // front: command queue decoupling the input port from the engine
    logic              cq_empty, cq_take;
    sjq_pkg::in_item_t cq_item;
    logic              res_valid;

    sjq_cmd_fifo u_cmd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (in_item),
        .full  (full),
        .pop   (cq_take),
        .dout  (cq_item),
        .empty (cq_empty)
    );

    // back: table probe and server sequencer, result held in output register
    sjq_engine #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_JOBS(MAX_JOBS)) u_eng
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cq_empty),
        .cmd       (cq_item),
        .cmd_take  (cq_take),
        .res_valid (res_valid),
        .res       (out_item),
        .res_ready (pop)
    );

    assign empty = !res_valid;

    // a result that is waiting stays put until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed before pop");
    // the engine only takes a command that is there
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        cq_take |-> !cq_empty)
        else $error("engine took from empty command queue");
endmodule
`default_nettype wire
